### hw/rtl/clws_pkg.sv
// Shared types and constants for the character display write sequencer.
// Used by clws_ctrl, clws_datapath and char_lcd_write_sequencer.
package clws_pkg;

	localparam logic [2:0] KIND_CMD        = 3'd0;
	localparam logic [2:0] KIND_CHAR       = 3'd1;
	localparam logic [2:0] KIND_STR_CHAR   = 3'd2;
	localparam logic [2:0] KIND_STR_FIRST  = 3'd3;
	localparam logic [2:0] KIND_SET_CURSOR = 3'd4;

	localparam logic [1:0] REG_FOUR_BIT_MODE      = 2'd0;
	localparam logic [1:0] REG_LINE_LENGTH        = 2'd1;
	localparam logic [1:0] REG_FIRST_ROW_ADDRESS  = 2'd2;
	localparam logic [1:0] REG_SECOND_ROW_ADDRESS = 2'd3;

	localparam logic [5:0] LINE_LENGTH_RESET  = 6'd16;
	localparam logic [7:0] FIRST_ROW_RESET    = 8'h80;
	localparam logic [7:0] SECOND_ROW_RESET   = 8'hC0;
	localparam logic [7:0] NIBBLE_MASK        = 8'hF0;

	typedef struct packed {
		logic load;
		logic byte_sel;
		logic nib_sel;
		logic last;
	} clws_cmd_t;

	typedef struct packed {
		logic have0;
		logic have1;
		logic four_bit;
	} clws_status_t;

endpackage

### hw/rtl/char_lcd_write_sequencer.sv
// Top level of the character display write sequencer.
// Instantiates clws_ctrl and clws_datapath; depends on clws_pkg.
//
// Usage:
//   The slave stream takes one item per transfer: s_tuser carries the kind,
//   s_tdata the byte, cursor row and column. The master stream gives one
//   enable strobe per transfer: m_tdata is the bus value, m_tuser the
//   register select, m_tlast marks the final strobe of an item.
//   The configuration port writes mode, line length and row addresses
//   through cfg_we, cfg_index and cfg_data; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
//   An item is accepted in the idle state and decoded in the check state,
//   then sends 0 to 4 strobes (two per byte in 4-bit mode, plus an optional
//   wrap move). The strobe sequencer handles one item at a time.
//   A stalled master holds the current strobe until m_tready rises.
//   Reset loads 8-bit mode, line length 16, row addresses 0x80 and 0xC0,
//   and clears the string character count.
module char_lcd_write_sequencer
	import clws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // value[7:0], row[9:8], column[15:10]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // bus_value[7:0]
	output logic        m_tuser,   // select_data[0]
	output logic        m_tlast
);

	clws_cmd_t    cmd;
	clws_status_t status;

	clws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	clws_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (s_tuser),
		.value       (s_tdata[7:0]),
		.row         (s_tdata[9:8]),
		.column      (s_tdata[15:10]),
		.cmd         (cmd),
		.status      (status),
		.select_data (m_tuser),
		.bus_value   (m_tdata),
		.last        (m_tlast)
	);

endmodule

### hw/rtl/clws_datapath.sv
// Datapath of the write sequencer: configuration registers, string counter,
// latched strobe bytes and strobe payload select. Depends on clws_pkg.
module clws_datapath
	import clws_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic [2:0]   kind,
	input  logic [7:0]   value,
	input  logic [1:0]   row,
	input  logic [5:0]   column,
	input  clws_cmd_t    cmd,
	output clws_status_t status,
	output logic         select_data,
	output logic [7:0]   bus_value,
	output logic         last
);

	logic       four_bit_q;
	logic [5:0] line_len_q;
	logic [7:0] row0_addr_q;
	logic [7:0] row1_addr_q;
	logic [6:0] cnt_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic       rs0_q;
	logic       have0_q;
	logic       have1_q;

	logic [6:0] cnt_base;
	logic [6:0] cnt_inc;
	logic       len_nz;
	logic       wrap1;
	logic       wrap0;
	logic [7:0] cur_addr;
	logic       cur_ok;
	logic [7:0] b0_d;
	logic [7:0] b1_d;
	logic       rs0_d;
	logic       have0_d;
	logic       have1_d;
	logic [6:0] cnt_d;
	logic [7:0] sel_byte;

	always_comb begin
		cnt_base = (kind == KIND_STR_FIRST) ? 7'd0 : cnt_q;
		cnt_inc  = cnt_base + 7'd1;
		len_nz   = (line_len_q != 6'd0);
		wrap1    = len_nz && (cnt_inc == {1'b0, line_len_q});
		wrap0    = len_nz && (cnt_inc >= {line_len_q, 1'b0});
		cur_addr = (row[0] ? row1_addr_q : row0_addr_q) + {2'b00, column};
		cur_ok   = (row[1] == 1'b0) && (column < line_len_q);
		b0_d     = value;
		b1_d     = wrap1 ? row1_addr_q : row0_addr_q;
		rs0_d    = 1'b0;
		have0_d  = 1'b0;
		have1_d  = 1'b0;
		cnt_d    = cnt_q;
		case (kind)
			KIND_CMD: begin
				have0_d = 1'b1;
			end
			KIND_CHAR: begin
				rs0_d   = 1'b1;
				have0_d = 1'b1;
			end
			KIND_STR_CHAR, KIND_STR_FIRST: begin
				rs0_d   = 1'b1;
				have0_d = 1'b1;
				have1_d = wrap1 || wrap0;
				cnt_d   = (cnt_inc >= {line_len_q, 1'b0}) ? 7'd0 : cnt_inc;
			end
			KIND_SET_CURSOR: begin
				b0_d    = cur_addr;
				have0_d = cur_ok;
			end
			default: begin
				have0_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q  <= 1'b0;
			line_len_q  <= LINE_LENGTH_RESET;
			row0_addr_q <= FIRST_ROW_RESET;
			row1_addr_q <= SECOND_ROW_RESET;
			cnt_q       <= 7'd0;
			have0_q     <= 1'b0;
			have1_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FOUR_BIT_MODE:      four_bit_q  <= cfg_data[0];
					REG_LINE_LENGTH:        line_len_q  <= cfg_data[5:0];
					REG_FIRST_ROW_ADDRESS:  row0_addr_q <= cfg_data;
					REG_SECOND_ROW_ADDRESS: row1_addr_q <= cfg_data;
					default:                four_bit_q  <= four_bit_q;
				endcase
			end
			if (cmd.load) begin
				cnt_q   <= cnt_d;
				have0_q <= have0_d;
				have1_q <= have1_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b0_q  <= b0_d;
			b1_q  <= b1_d;
			rs0_q <= rs0_d;
		end
	end

	always_comb begin
		sel_byte = cmd.byte_sel ? b1_q : b0_q;
		if (!four_bit_q) begin
			bus_value = sel_byte;
		end else if (!cmd.nib_sel) begin
			bus_value = sel_byte & NIBBLE_MASK;
		end else begin
			bus_value = {sel_byte[3:0], 4'h0};
		end
		select_data     = cmd.byte_sel ? 1'b0 : rs0_q;
		last            = cmd.last;
		status.have0    = have0_q;
		status.have1    = have1_q;
		status.four_bit = four_bit_q;
	end

endmodule

### hw/rtl/clws_ctrl.sv
// Controller of the write sequencer: accepts an item, then steps through
// its bytes and nibbles one strobe per transfer. Depends on clws_pkg.
module clws_ctrl
	import clws_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  clws_status_t status,
	output clws_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;
	logic   bi_q;
	logic   nib_q;
	logic   is_last;

	assign is_last = (bi_q | ~status.have1) & (~status.four_bit | nib_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
			bi_q    <= 1'b0;
			nib_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					bi_q  <= 1'b0;
					nib_q <= 1'b0;
					if (status.have0) begin
						valid_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (is_last) begin
							valid_q <= 1'b0;
							ready_q <= 1'b1;
							state_q <= ST_IDLE;
						end else if (status.four_bit && !nib_q) begin
							nib_q <= 1'b1;
						end else begin
							bi_q  <= 1'b1;
							nib_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		in_ready     = ready_q;
		out_valid    = valid_q;
		cmd.load     = in_valid && ready_q;
		cmd.byte_sel = bi_q;
		cmd.nib_sel  = nib_q;
		cmd.last     = is_last;
	end

endmodule
